### hdl/ech_pkg.sv
// Shared types and constants for the event coalescing holdoff table.
// Used by ech_cell, ech_chain and event_coalesce_holdoff_table_top.
`timescale 1ns / 1ps

package ech_pkg;

    localparam int KEY_W           = 32;
    localparam int FLAGS_W         = 8;
    localparam int TICK_W          = 8;
    localparam int DATA_W          = KEY_W + FLAGS_W;
    localparam int MAX_DEPTH       = 64;
    localparam int RANK_W          = $clog2(MAX_DEPTH);
    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic [TICK_W-1:0] DEF_WAIT_TICKS    = TICK_W'(5);
    localparam logic [TICK_W-1:0] DEF_HOLDOFF_TICKS = TICK_W'(5);

    // command carried in tuser
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic REG_WAIT    = 1'b0;
    localparam logic REG_HOLDOFF = 1'b1;

    // slot modes
    localparam logic MODE_WAIT = 1'b0;
    localparam logic MODE_HOLD = 1'b1;

    // probe kinds travelling along the chain
    localparam logic [2:0] PK_NONE   = 3'd0;
    localparam logic [2:0] PK_LOOKUP = 3'd1;
    localparam logic [2:0] PK_ALLOC  = 3'd2;
    localparam logic [2:0] PK_SCAN   = 3'd3;
    localparam logic [2:0] PK_RENUM  = 3'd4;
    localparam logic [2:0] PK_AGE    = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [KEY_W-1:0]   key;
        logic [FLAGS_W-1:0] flags;
        logic [RANK_W-1:0]  rank;     // queue rank looked for, or tail rank on lookup
        logic [RANK_W-1:0]  aux;      // new rank on renumber
        logic               hit;
        logic               moved;    // holdoff slot moved to the wait queue
        logic               expired;
    } probe_t;

    typedef struct packed {
        logic [TICK_W-1:0] wait_ticks;
        logic [TICK_W-1:0] holdoff_ticks;
    } cfg_t;

endpackage

### hdl/ech_cell.sv
// One table slot plus one probe stage of the chain.
// Depends on ech_pkg for probe_t, cfg_t and the probe kind codes.
`timescale 1ns / 1ps

module ech_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  ech_pkg::cfg_t   cfg,
    input  ech_pkg::probe_t pin,
    output ech_pkg::probe_t pout
);

    localparam int TW = ech_pkg::TICK_W;

    logic                        valid_reg, valid_next;
    logic                        mode_reg, mode_next;
    logic [ech_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [ech_pkg::FLAGS_W-1:0] flags_reg, flags_next;
    logic [TW-1:0]               count_reg, count_next;
    logic [ech_pkg::RANK_W-1:0]  rank_reg, rank_next;
    ech_pkg::probe_t             probe_reg, probe_next;
    logic                        waiting_here;

    assign waiting_here = valid_reg && (mode_reg == ech_pkg::MODE_WAIT)
                          && (rank_reg == pin.rank);

    always_comb
    begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        flags_next = flags_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        probe_next = pin;
        case (pin.kind)
            ech_pkg::PK_LOOKUP:
            begin
                if (valid_reg && (key_reg == pin.key))
                begin
                    probe_next.hit = 1'b1;
                    count_next     = cfg.wait_ticks;
                    if (mode_reg == ech_pkg::MODE_WAIT)
                    begin
                        flags_next = flags_reg | pin.flags;
                    end
                    else
                    begin
                        mode_next        = ech_pkg::MODE_WAIT;
                        flags_next       = pin.flags;
                        rank_next        = pin.rank;
                        probe_next.moved = 1'b1;
                    end
                end
            end
            ech_pkg::PK_ALLOC:
            begin
                // first free slot down the chain claims the key
                if (!valid_reg && !pin.hit)
                begin
                    valid_next     = 1'b1;
                    mode_next      = ech_pkg::MODE_HOLD;
                    key_next       = pin.key;
                    flags_next     = pin.flags;
                    count_next     = cfg.holdoff_ticks;
                    probe_next.hit = 1'b1;
                end
            end
            ech_pkg::PK_SCAN:
            begin
                if (waiting_here)
                begin
                    probe_next.hit   = 1'b1;
                    probe_next.key   = key_reg;
                    probe_next.flags = flags_reg;
                    if (count_reg <= TW'(1))
                    begin
                        probe_next.expired = 1'b1;
                        mode_next          = ech_pkg::MODE_HOLD;
                        count_next         = cfg.holdoff_ticks;
                    end
                    else
                    begin
                        count_next = count_reg - TW'(1);
                    end
                end
            end
            ech_pkg::PK_RENUM:
            begin
                if (waiting_here)
                begin
                    rank_next = pin.aux;
                end
            end
            ech_pkg::PK_AGE:
            begin
                if (valid_reg && (mode_reg == ech_pkg::MODE_HOLD))
                begin
                    if (count_reg <= TW'(1))
                    begin
                        valid_next = 1'b0;
                        mode_next  = ech_pkg::MODE_WAIT;
                    end
                    else
                    begin
                        count_next = count_reg - TW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mode_reg  <= ech_pkg::MODE_WAIT;
            probe_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg   <= key_next;
            flags_reg <= flags_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    assign pout = probe_reg;

endmodule

### hdl/ech_chain.sv
// Row of TABLE_DEPTH slot cells; probes enter at cell 0 and leave at the far end.
// Depends on ech_pkg and ech_cell.
`timescale 1ns / 1ps

module ech_chain
#(
    parameter int TABLE_DEPTH = ech_pkg::DEF_TABLE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  ech_pkg::cfg_t   cfg,
    input  ech_pkg::probe_t head,
    output ech_pkg::probe_t tail
);

    ech_pkg::probe_t link [TABLE_DEPTH+1];

    assign link[0] = head;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ech_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .cfg   (cfg),
            .pin   (link[i]),
            .pout  (link[i+1])
        );
    end

    assign tail = link[TABLE_DEPTH];

endmodule

### hdl/event_coalesce_holdoff_table_top.sv
// Top level of the event coalescing holdoff table: controller, output stage, config.
// Depends on ech_pkg and ech_chain (which holds the ech_cell row).
`timescale 1ns / 1ps

// Usage
//  s_axis: one beat per item. tuser = command (tick when set), tdata = key then flags.
//  m_axis: one beat per emitted event. tdata = key then flags, tuser = overflow,
//          tlast marks the final beat caused by one input beat.
//  cfg:    register writes (index 0 = wait ticks, 1 = holdoff ticks), always ready;
//          write only while the block is idle.
//  Every input beat is turned into probes that walk the row of TABLE_DEPTH slot cells,
//  one cell per cycle while the row is not stalled:
//   event, key known:    one lookup probe, no output beat
//   event, key unknown:  a lookup then an allocate probe, one output beat
//   tick with W waiting: W scan probes, then an ageing probe (only that if none wait)
//  One item is worked on at a time; s_axis_tready is high only between items.
//  Reset empties the table and sets both tick registers to 5.
//  A stalled receiver holds the whole chain once a second result is ready to leave;
//  one result sits in the output register and one is held back to mark tlast.
module event_coalesce_holdoff_table_top
#(
    parameter int TABLE_DEPTH = ech_pkg::DEF_TABLE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ech_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] key, [39:32] flags
    input  logic                       s_axis_tuser,  // [0] command
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ech_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] out_key, [39:32] out_flags
    output logic                       m_axis_tuser,  // [0] overflow
    output logic                       m_axis_tlast,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [ech_pkg::TICK_W-1:0] cfg_data
);

    localparam int KW   = ech_pkg::KEY_W;
    localparam int FW   = ech_pkg::FLAGS_W;
    localparam int RW   = ech_pkg::RANK_W;
    localparam int WL_W = $clog2(TABLE_DEPTH + 1);

    // controller states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;  // lookup probe in flight
    localparam logic [2:0] S_ALLOC = 3'd2;  // allocate probe in flight
    localparam logic [2:0] S_SCAN  = 3'd3;  // scanning the wait queue
    localparam logic [2:0] S_AGEQ  = 3'd4;  // send the holdoff ageing probe
    localparam logic [2:0] S_FLUSH = 3'd5;  // release the held result with tlast

    logic [2:0]      state_reg, state_next;
    logic [WL_W-1:0] wlen_reg, wlen_next;   // waiting slots, i.e. queue length
    logic [WL_W-1:0] iss_reg, iss_next;     // next scan rank to issue
    logic [WL_W-1:0] keep_reg, keep_next;   // survivors counted so far this tick

    logic          pend_valid_reg, pend_valid_next;
    logic [KW-1:0] pend_key_reg, pend_key_next;
    logic [FW-1:0] pend_flags_reg, pend_flags_next;

    logic          out_valid_reg, out_valid_next;
    logic [KW-1:0] out_key_reg, out_key_next;
    logic [FW-1:0] out_flags_reg, out_flags_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_last_reg, out_last_next;

    logic [ech_pkg::TICK_W-1:0] wait_reg, hold_reg;

    ech_pkg::cfg_t   cfg;
    ech_pkg::probe_t head, tail;
    logic            out_free, scan_emit, need_out, adv, survivor;

    assign cfg.wait_ticks    = wait_reg;
    assign cfg.holdoff_ticks = hold_reg;

    // a beat leaving the chain that must be loaded into the output register
    // stalls the whole row while the output register is still occupied
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign scan_emit = (tail.kind == ech_pkg::PK_SCAN) && tail.hit && tail.expired;
    assign need_out  = (tail.kind == ech_pkg::PK_ALLOC) || (scan_emit && pend_valid_reg);
    assign adv       = !need_out || out_free;
    assign survivor  = (tail.kind == ech_pkg::PK_SCAN) && tail.hit && !tail.expired;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        wlen_next       = wlen_reg;
        iss_next        = iss_reg;
        keep_next       = keep_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_flags_next = pend_flags_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_key_next    = out_key_reg;
        out_flags_next  = out_flags_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        head            = '0;
        head.kind       = ech_pkg::PK_NONE;

        if (adv)
        begin
            // probes leaving the chain
            case (tail.kind)
                ech_pkg::PK_LOOKUP:
                begin
                    if (tail.hit)
                    begin
                        if (tail.moved)
                        begin
                            wlen_next = wlen_reg + WL_W'(1);
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        head.kind  = ech_pkg::PK_ALLOC;
                        head.key   = tail.key;
                        head.flags = tail.flags;
                        state_next = S_ALLOC;
                    end
                end
                ech_pkg::PK_ALLOC:
                begin
                    // emit the new event; with no free slot left it is passed on untracked (overflow)
                    out_valid_next = 1'b1;
                    out_key_next   = tail.key;
                    out_flags_next = tail.flags;
                    out_ovf_next   = !tail.hit;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                ech_pkg::PK_SCAN:
                begin
                    if (scan_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_key_next   = pend_key_reg;
                            out_flags_next = pend_flags_reg;
                            out_ovf_next   = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_key_next   = tail.key;
                        pend_flags_next = tail.flags;
                    end
                    if (survivor)
                    begin
                        keep_next = keep_reg + WL_W'(1);
                    end
                    // compact the queue: survivor takes the next free rank
                    head.kind = ech_pkg::PK_RENUM;
                    head.rank = tail.rank;
                    head.aux  = RW'(keep_reg);
                    if (tail.rank == RW'(wlen_reg - WL_W'(1)))
                    begin
                        wlen_next  = keep_next;
                        state_next = S_AGEQ;
                    end
                end
                default:
                begin
                end
            endcase

            // probes entering the chain
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser == ech_pkg::CMD_TICK)
                        begin
                            keep_next = '0;
                            if (wlen_reg == '0)
                            begin
                                head.kind  = ech_pkg::PK_AGE;
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                head.kind  = ech_pkg::PK_SCAN;
                                head.rank  = '0;
                                iss_next   = WL_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        else
                        begin
                            head.kind  = ech_pkg::PK_LOOKUP;
                            head.key   = s_axis_tdata[KW-1:0];
                            head.flags = s_axis_tdata[KW+FW-1:KW];
                            head.rank  = RW'(wlen_reg);
                            state_next = S_LOOK;
                        end
                    end
                end
                S_SCAN:
                begin
                    // scan issue ends before the first scan probe returns
                    if (iss_reg < wlen_reg)
                    begin
                        head.kind = ech_pkg::PK_SCAN;
                        head.rank = RW'(iss_reg);
                        iss_next  = iss_reg + WL_W'(1);
                    end
                end
                S_AGEQ:
                begin
                    head.kind  = ech_pkg::PK_AGE;
                    state_next = S_FLUSH;
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_key_next    = pend_key_reg;
                        out_flags_next  = pend_flags_reg;
                        out_ovf_next    = 1'b0;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                S_LOOK, S_ALLOC:
                begin
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wlen_reg       <= '0;
            iss_reg        <= '0;
            keep_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            wait_reg       <= ech_pkg::DEF_WAIT_TICKS;
            hold_reg       <= ech_pkg::DEF_HOLDOFF_TICKS;
        end
        else
        begin
            state_reg      <= state_next;
            wlen_reg       <= wlen_next;
            iss_reg        <= iss_next;
            keep_reg       <= keep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ech_pkg::REG_WAIT:    wait_reg <= cfg_data;
                    ech_pkg::REG_HOLDOFF: hold_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_key_reg   <= pend_key_next;
        pend_flags_reg <= pend_flags_next;
        out_key_reg    <= out_key_next;
        out_flags_reg  <= out_flags_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    ech_chain
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cfg   (cfg),
        .head  (head),
        .tail  (tail)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_flags_reg, out_key_reg};
    assign m_axis_tuser  = out_ovf_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### verif/tb_event_coalesce_holdoff_table_top.sv
// Self-checking testbench for event_coalesce_holdoff_table_top: directed and random beats,
// emissions predicted by a behavioural copy of the slot table and checked beat by beat.
// Depends on ech_pkg and the event_coalesce_holdoff_table_top RTL.
`timescale 1ns / 1ps

module tb_event_coalesce_holdoff_table_top;

    localparam int KEY_W           = ech_pkg::KEY_W;
    localparam int FLAGS_W         = ech_pkg::FLAGS_W;
    localparam int TICK_W          = ech_pkg::TICK_W;
    localparam int DATA_W          = ech_pkg::DATA_W;
    localparam int TABLE_DEPTH     = ech_pkg::DEF_TABLE_DEPTH;
    localparam int KEY_POOL        = 24;
    localparam int PHASE_BEATS     = 36;
    // room for the longest walk through the row, with plenty of margin
    localparam int SETTLE_CYCLES   = 4 * TABLE_DEPTH + 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic CMD_EVENT     = ~ech_pkg::CMD_TICK;

    // one emitted event as it should appear on m_axis
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FLAGS_W-1:0] flags;
        logic               overflow;
        logic               last;
    } emission_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;   // [31:0] key, [39:32] flags
    logic                s_axis_tuser = 1'b0; // [0] command
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;        // [31:0] out_key, [39:32] out_flags
    logic                m_axis_tuser;        // [0] overflow
    logic                m_axis_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = ech_pkg::REG_WAIT;
    logic [TICK_W-1:0]   cfg_data = '0;

    // predicted table, kept in step with every accepted beat
    logic                tbl_live  [TABLE_DEPTH];
    logic                tbl_mode  [TABLE_DEPTH];
    logic [KEY_W-1:0]    tbl_key   [TABLE_DEPTH];
    logic [FLAGS_W-1:0]  tbl_flags [TABLE_DEPTH];
    logic [TICK_W-1:0]   tbl_timer [TABLE_DEPTH];
    int                  wait_line[$];          // waiting slots, oldest first
    logic [TICK_W-1:0]   quiet_ticks = ech_pkg::DEF_WAIT_TICKS;
    logic [TICK_W-1:0]   hold_ticks  = ech_pkg::DEF_HOLDOFF_TICKS;

    emission_t           emissions_due[$];
    logic [KEY_W-1:0]    key_pool[KEY_POOL];
    int                  beats_sent = 0;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  sender_idle_pct = 26;
    int                  receiver_stall_pct = 81;

    event_coalesce_holdoff_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    task automatic coalesce_event(input logic [KEY_W-1:0] key, input logic [FLAGS_W-1:0] fl);
        int hit;
        int spare;
        hit = -1;
        spare = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (tbl_live[i] && tbl_key[i] == key)
                hit = i;
            if (!tbl_live[i])
                spare = i;               // ends on the lowest free slot
        end
        if (hit >= 0)
        begin
            // known key: never emitted here, only (re)queued
            if (tbl_mode[hit] == ech_pkg::MODE_WAIT)
                tbl_flags[hit] = tbl_flags[hit] | fl;
            else
            begin
                tbl_mode[hit]  = ech_pkg::MODE_WAIT;
                tbl_flags[hit] = fl;
                wait_line.push_back(hit);
            end
            tbl_timer[hit] = quiet_ticks;
        end
        else if (spare < 0)
            emissions_due.push_back('{key: key, flags: fl, overflow: 1'b1, last: 1'b1});
        else
        begin
            tbl_live[spare]  = 1'b1;
            tbl_mode[spare]  = ech_pkg::MODE_HOLD;
            tbl_key[spare]   = key;
            tbl_flags[spare] = fl;
            tbl_timer[spare] = hold_ticks;
            emissions_due.push_back('{key: key, flags: fl, overflow: 1'b0, last: 1'b1});
        end
    endtask

    task automatic age_table();
        int still_waiting[$];
        int fired[$];
        int s;
        foreach (wait_line[i])
        begin
            s = wait_line[i];
            if (tbl_timer[s] <= 1)
            begin
                fired.push_back(s);
                tbl_mode[s]  = ech_pkg::MODE_HOLD;
                tbl_timer[s] = hold_ticks;
            end
            else
            begin
                tbl_timer[s] = tbl_timer[s] - 1'b1;
                still_waiting.push_back(s);
            end
        end
        wait_line = still_waiting;
        foreach (fired[i])
            emissions_due.push_back('{key: tbl_key[fired[i]], flags: tbl_flags[fired[i]],
                                      overflow: 1'b0, last: (i == fired.size() - 1)});
        // holdoff ageing includes slots that only just entered holdoff
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tbl_live[i] && tbl_mode[i] == ech_pkg::MODE_HOLD)
            begin
                if (tbl_timer[i] <= 1)
                begin
                    tbl_live[i] = 1'b0;
                    tbl_mode[i] = ech_pkg::MODE_WAIT;
                end
                else
                    tbl_timer[i] = tbl_timer[i] - 1'b1;
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : emission_check
        emission_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (emissions_due.size() == 0)
                report_mismatch($sformatf("unexpected beat key %h flags %h ovf %b last %b",
                                          m_axis_tdata[KEY_W-1:0], m_axis_tdata[DATA_W-1:KEY_W],
                                          m_axis_tuser, m_axis_tlast));
            else
            begin
                want = emissions_due.pop_front();
                if (m_axis_tdata[KEY_W-1:0] !== want.key ||
                    m_axis_tdata[DATA_W-1:KEY_W] !== want.flags ||
                    m_axis_tuser !== want.overflow || m_axis_tlast !== want.last)
                    report_mismatch($sformatf("got key %h flags %h ovf %b last %b, %s",
                                              m_axis_tdata[KEY_W-1:0],
                                              m_axis_tdata[DATA_W-1:KEY_W],
                                              m_axis_tuser, m_axis_tlast,
                                              $sformatf("want %h %h %b %b", want.key,
                                                        want.flags, want.overflow,
                                                        want.last)));
            end
        end
    end

    // watchdog: any beat on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- drivers

    // Called at a rising edge; returns at the edge where the beat is taken.
    // tvalid is only dropped for a gap, so back-to-back beats keep it high.
    task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [FLAGS_W-1:0] fl);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {fl, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == ech_pkg::CMD_TICK)
            age_table();
        else
            coalesce_event(key, fl);
        beats_sent++;
    endtask

    task automatic send_event(input logic [KEY_W-1:0] key, input logic [FLAGS_W-1:0] fl);
        send_beat(CMD_EVENT, key, fl);
    endtask

    // key and flags are don't-care on a tick, so scramble them
    task automatic send_tick();
        send_beat(ech_pkg::CMD_TICK, $urandom, FLAGS_W'($urandom_range(0, 255)));
    endtask

    // Wait for every predicted beat, then long enough for walks that emit nothing to finish.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (emissions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers in one burst; cfg_valid stays high between the two writes.
    task automatic write_tick_regs(input logic [TICK_W-1:0] quiet, input logic [TICK_W-1:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= ech_pkg::REG_WAIT;
        cfg_data  <= quiet;
        do
            @(posedge clk);
        while (!cfg_ready);
        quiet_ticks = quiet;
        cfg_index <= ech_pkg::REG_HOLDOFF;
        cfg_data  <= hold;
        do
            @(posedge clk);
        while (!cfg_ready);
        hold_ticks = hold;
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // New key, repeat in holdoff, repeat while waiting (flags OR).
    // Key and flag extremes ride along.
    task automatic test_first_seen_and_merge();
        write_tick_regs(TICK_W'(2), TICK_W'(3));
        send_event(32'h0000_0000, 8'hFF);
        send_event(32'hFFFF_FFFF, 8'h00);
        send_event(32'h0000_0000, 8'h01);   // holdoff -> waiting, flags replaced
        send_event(32'h0000_0000, 8'h80);   // waiting -> flags merged, timer reloaded
    endtask

    // Fill the remaining slots, then one more unknown key overflows untracked.
    // Ticks afterwards emit the merged key and empty the table again.
    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_event(32'h1000_0000 + i, FLAGS_W'(i));
        send_event(32'h5A5A_A5A5, 8'hA5);
        repeat (4) send_tick();
    endtask

    // Zero and one tick settings: expiry on the very next tick, holdoff freed on the
    // tick that entered it.
    task automatic test_zero_and_one_tick();
        for (int z = 0; z < 2; z++)
        begin
            drain_and_settle();
            write_tick_regs(TICK_W'(z), TICK_W'(z));
            send_event(32'h8000_0001 + z, 8'h3C);
            send_event(32'h8000_0001 + z, 8'hC3);
            send_tick();
            send_tick();
        end
    endtask

    // Well-formed burst: n keys seen, repeated (some twice), then ticks past a wait of up to 6.
    // Now and then cut short to leave stragglers for later ticks.
    task automatic run_burst();
        int n;
        int first;
        int cut;
        int k;
        n = $urandom_range(1, TABLE_DEPTH);
        first = $urandom_range(0, KEY_POOL - 1);
        cut = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
            send_event(key_pool[(first + i) % KEY_POOL], FLAGS_W'($urandom_range(0, 255)));
        if (cut != 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                k = (first + i) % KEY_POOL;
                if ($urandom_range(0, 4) != 0)
                    send_event(key_pool[k], FLAGS_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    send_event(key_pool[k], FLAGS_W'($urandom_range(0, 255)));
            end
        end
        if (cut != 1)
            repeat (((quiet_ticks > 6) ? 6 : int'(quiet_ticks)) + 1 + $urandom_range(0, 2))
                send_tick();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input logic [TICK_W-1:0] quiet,
                                       input logic [TICK_W-1:0] hold);
        int goal;
        int pick;
        drain_and_settle();
        sender_idle_pct = sender_idle;
        receiver_stall_pct = receiver_stall;
        write_tick_regs(quiet, hold);
        goal = beats_sent + PHASE_BEATS;
        while (beats_sent < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                run_burst();
            else if (pick == 6)
                send_event($urandom, FLAGS_W'($urandom_range(0, 255)));   // stray key
            else if (pick == 7)
                send_event(key_pool[$urandom_range(0, KEY_POOL - 1)],
                           FLAGS_W'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 6)) send_tick();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_live[i]  = 1'b0;
            tbl_mode[i]  = ech_pkg::MODE_WAIT;
            tbl_key[i]   = '0;
            tbl_flags[i] = '0;
            tbl_timer[i] = '0;
        end
        foreach (key_pool[i])
            key_pool[i] = $urandom;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_seen_and_merge();
        test_table_full();
        test_zero_and_one_tick();
        test_random_traffic(26, 81, TICK_W'(3), TICK_W'(4));
        test_random_traffic(81, 26, TICK_W'($urandom_range(1, 6)),
                            TICK_W'($urandom_range(1, 8)));
        test_random_traffic(0, 0, TICK_W'(255), TICK_W'(255));
        drain_and_settle();

        if (mismatches == 0 && emissions_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
